// ===== rtl/core/wnm_pkg.sv =====
// ----------------------------------------------------------------------------
// wnm_pkg
// Shared types, constants and helpers for the wildcard name matcher.
// ----------------------------------------------------------------------------
package wnm_pkg;

    localparam int PATTERN_MAX = 64;
    localparam int LEN_W       = $clog2(PATTERN_MAX + 1);
    localparam int IDX_W       = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

    localparam logic [7:0] STAR_CODE  = 8'h2A;
    localparam logic [7:0] QMARK_CODE = 8'h3F;

    localparam logic CMD_PATTERN = 1'b0;
    localparam logic CMD_NAME    = 1'b1;

    typedef struct packed {
        logic       command;
        logic [7:0] char_code;
        logic       last;
    } wnm_in_t;

    typedef struct packed {
        logic matched;
        logic pattern_too_long;
    } wnm_out_t;

    // a..z fold to A..Z, every other byte passes unchanged
    function automatic logic [7:0] fold_char(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h61 && c <= 8'h7A) begin
            r = c - 8'h20;
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/wnm_engine.sv =====
// ----------------------------------------------------------------------------
// wnm_engine
// Pattern store and bit-parallel active-position update; one item per step.
// ----------------------------------------------------------------------------
module wnm_engine (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step,
    input  wnm_pkg::wnm_in_t item,
    output logic             res_valid,
    output wnm_pkg::wnm_out_t result
);
    import wnm_pkg::*;

    // Runs of stars are stored as a single star, so star closure is one step.
    // raw_reg counts every stored-or-merged byte for the truncation limit.
    logic [7:0]         store_reg [PATTERN_MAX];
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [LEN_W-1:0]   raw_reg, raw_next;
    logic               closed_reg, closed_next;
    logic               ovf_reg, ovf_next;
    logic               prev_star_reg, prev_star_next;
    logic               name_open_reg, name_open_next;
    logic [PATTERN_MAX:0] active_reg, active_next;

    logic               wr_en;
    logic [IDX_W-1:0]   wr_idx;
    logic [7:0]         c_fold;

    logic [PATTERN_MAX-1:0] pos_valid, pos_star, pos_hit;
    logic [PATTERN_MAX:0]   start_vec, cur_vec, nxt_raw, nxt_vec;

    logic [LEN_W-1:0]   base_len, base_raw;
    logic               base_prev_star;

    assign c_fold = fold_char(item.char_code);

    always_comb begin
        for (int i = 0; i < PATTERN_MAX; i++) begin
            pos_valid[i] = LEN_W'(i) < len_reg;
            pos_star[i]  = pos_valid[i] && (store_reg[i] == STAR_CODE);
            pos_hit[i]   = pos_valid[i] && !pos_star[i] &&
                           ((store_reg[i] == QMARK_CODE) || (store_reg[i] == c_fold));
        end
    end

    always_comb begin
        start_vec    = '0;
        start_vec[0] = 1'b1;
        start_vec[1] = pos_star[0];
        cur_vec      = name_open_reg ? active_reg : start_vec;

        nxt_raw = '0;
        for (int i = 0; i < PATTERN_MAX; i++) begin
            nxt_raw[i]   = nxt_raw[i]   | (cur_vec[i] & pos_star[i]);
            nxt_raw[i+1] = nxt_raw[i+1] | (cur_vec[i] & pos_hit[i]);
        end

        // a star never follows a star in the store: one closure step is enough
        nxt_vec    = nxt_raw;
        for (int i = 0; i < PATTERN_MAX; i++) begin
            nxt_vec[i+1] = nxt_raw[i+1] | (nxt_raw[i] & pos_star[i]);
        end
    end

    always_comb begin
        len_next       = len_reg;
        raw_next       = raw_reg;
        closed_next    = closed_reg;
        ovf_next       = ovf_reg;
        prev_star_next = prev_star_reg;
        name_open_next = name_open_reg;
        active_next    = active_reg;
        wr_en          = 1'b0;
        res_valid      = 1'b0;

        base_len       = closed_reg ? '0 : len_reg;
        base_raw       = closed_reg ? '0 : raw_reg;
        base_prev_star = closed_reg ? 1'b0 : prev_star_reg;
        wr_idx         = base_len[IDX_W-1:0];

        result.matched          = nxt_vec[len_reg];
        result.pattern_too_long = ovf_reg;

        if (step) begin
            if (item.command == CMD_PATTERN) begin
                name_open_next = 1'b0;
                closed_next    = item.last;
                len_next       = base_len;
                raw_next       = base_raw;
                prev_star_next = base_prev_star;
                ovf_next       = closed_reg ? 1'b0 : ovf_reg;
                if (base_raw < LEN_W'(PATTERN_MAX)) begin
                    raw_next = base_raw + 1'b1;
                    if (!(base_prev_star && c_fold == STAR_CODE)) begin
                        wr_en          = 1'b1;
                        len_next       = base_len + 1'b1;
                        prev_star_next = (c_fold == STAR_CODE);
                    end
                end else begin
                    ovf_next = 1'b1;
                end
            end else begin
                closed_next    = 1'b1;
                active_next    = nxt_vec;
                name_open_next = !item.last;
                res_valid      = item.last;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg       <= '0;
            raw_reg       <= '0;
            closed_reg    <= 1'b1;
            ovf_reg       <= 1'b0;
            prev_star_reg <= 1'b0;
            name_open_reg <= 1'b0;
            active_reg    <= '0;
        end else begin
            len_reg       <= len_next;
            raw_reg       <= raw_next;
            closed_reg    <= closed_next;
            ovf_reg       <= ovf_next;
            prev_star_reg <= prev_star_next;
            name_open_reg <= name_open_next;
            active_reg    <= active_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_reg[wr_idx] <= c_fold;
        end
    end

endmodule

// ===== rtl/core/wildcard_name_match_top.sv =====
// ----------------------------------------------------------------------------
// wildcard_name_match_top
// Case-insensitive glob matcher ('*' and '?') over a streamed name.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel carries items: command 0 loads a pattern byte, command 1 feeds
//   a name byte; last closes the pattern or the name. A pattern byte after a
//   closed pattern starts a new one; bytes past 64 are dropped and flagged.
//   m_ channel returns one item per name, on its last byte: matched and
//   pattern_too_long.
//   Throughput: one item per cycle, unless a final name byte waits behind a
//   held result. An accepted item sits in the input register while the
//   matcher updates its active-position vector; the result register loads
//   as the last name byte leaves the input register, raising m_valid.
//   If the receiver stalls, the result register holds; pattern bytes and
//   non-final name bytes keep flowing, and s_ready drops only when a second
//   result is waiting behind a held one.
//   Reset (aresetn low, synchronous) empties the pattern, closes it and
//   drops any open name; an empty pattern matches no name.
// ----------------------------------------------------------------------------
module wildcard_name_match_top (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  wnm_pkg::wnm_in_t  s_item,
    output logic              m_valid,
    input  logic              m_ready,
    output wnm_pkg::wnm_out_t m_item
);
    import wnm_pkg::*;

    logic     in_valid_reg;
    wnm_in_t  in_item_reg;
    logic     out_valid_reg;
    wnm_out_t out_item_reg;

    logic     emits;
    logic     proceed;
    logic     res_valid;
    wnm_out_t result;

    assign emits   = (in_item_reg.command == CMD_NAME) && in_item_reg.last;
    assign proceed = in_valid_reg && (!emits || !out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || proceed;

    wnm_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (proceed),
        .item      (in_item_reg),
        .res_valid (res_valid),
        .result    (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (proceed) begin
                in_valid_reg <= 1'b0;
            end
            if (res_valid) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
        if (res_valid) begin
            out_item_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;

endmodule
